// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
package bba_pkg;

  localparam int REQ_W    = 26;
  localparam int HANDLE_W = 6;
  localparam int OFS_W    = 25;
  localparam int LVL_W    = 3;
  localparam int SHIFT_W  = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_USED   = 2'd1,
    ST_SPLIT  = 2'd2,
    ST_FULL   = 2'd3
  } node_st_t;

  typedef enum logic [1:0] {
    RSP_OK      = 2'd0,
    RSP_NOSPACE = 2'd1,
    RSP_BADFREE = 2'd2
  } rsp_code_t;

  // controller -> datapath
  typedef struct packed {
    logic      clr_step;
    logic      accept;
    logic      calc_want;
    logic      walk_init;
    logic      srch_step;
    logic      free_rd;
    logic      loc_step;
    logic      mark;
    logic      up_wr;
    logic      res_load;
    rsp_code_t res_code;
    logic      out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic nosp;
    logic srch_found;
    logic srch_end;
    logic free_ok;
    logic loc_done;
    logic at_top;
    logic up_last;
  } sts_t;

endpackage

// ===== hdl/bba_if.sv =====
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [bba_pkg::REQ_W-1:0]    request_bytes;
  logic [bba_pkg::HANDLE_W-1:0] free_handle;

  modport source (output valid, mode, request_bytes, free_handle, input ready);
  modport sink   (input valid, mode, request_bytes, free_handle, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bba_pkg::HANDLE_W-1:0] block_handle;
  logic [bba_pkg::OFS_W-1:0]    block_offset;
  logic [bba_pkg::LVL_W-1:0]    block_level;

  modport source (output valid, status, block_handle, block_offset, block_level,
                  input ready);
  modport sink   (input valid, status, block_handle, block_offset, block_level,
                  output ready);
endinterface

// ===== hdl/buddy_block_allocator.sv =====
// Binary buddy allocator over a tree of LEVELS+1 levels (2^(LEVELS+1)-1 nodes).
// Channels: req carries mode (0 allocate, 1 free), request_bytes and free_handle;
// rsp returns status, block_handle, block_offset and block_level, one per request.
// cfg_we/cfg_wdata write min_block_shift (reset 10); write it only while idle.
// Requests are served one at a time; req.ready is high only while the block idles.
// Allocate: size the request, then probe tree nodes in preorder (each read,
// then evaluated), mark the block found, read and write back each ancestor,
// and load the output register. Free: read and check the handle, walk down
// to it from the root, mark it, update each ancestor and load the output.
// An oversized request, a bad free and a search that finds no block go
// straight to the output without marking. The node memory has a single write
// port, so each ancestor is read first and then written back.
// Reset clears the tree with a pass over its 2^(LEVELS+1)-1 nodes (63 at LEVELS=5)
// during which no request is taken; configuration writes are taken throughout.
// A result waits in the output register while rsp.ready is low; the next
// request is still taken and worked on, and its result waits in the block
// until the output register is free.
module buddy_block_allocator #(
  parameter int LEVELS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bba_pkg::SHIFT_W-1:0] cfg_wdata,
  bba_req_if.sink                     req,
  bba_rsp_if.source                   rsp
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_dpath #(
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (req.mode),
    .in_bytes   (req.request_bytes),
    .in_handle  (req.free_handle),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (rsp.status),
    .out_handle (rsp.block_handle),
    .out_offset (rsp.block_offset),
    .out_level  (rsp.block_level)
  );

endmodule

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_mode,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_PROBE,
    S_EVAL,
    S_CHECK_RD,
    S_CHECK,
    S_LOCATE,
    S_MARK,
    S_UP_RD,
    S_UP_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_code = bba_pkg::RSP_OK;
    state_next   = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = (req_mode == bba_pkg::MODE_FREE) ? S_CHECK_RD : S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.calc_want = 1'b1;
        cmd.walk_init = 1'b1;
        if (sts.nosp) begin
          cmd.res_load = 1'b1;
          cmd.res_code = bba_pkg::RSP_NOSPACE;
          state_next   = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: state_next = S_EVAL;
      S_EVAL: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_found) begin
          state_next = S_MARK;
        end else if (sts.srch_end) begin
          cmd.res_load = 1'b1;
          cmd.res_code = bba_pkg::RSP_NOSPACE;
          state_next   = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_CHECK_RD: begin
        cmd.free_rd = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (sts.free_ok) begin
          cmd.walk_init = 1'b1;
          state_next    = S_LOCATE;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = bba_pkg::RSP_BADFREE;
          state_next   = S_DONE;
        end
      end
      S_LOCATE: begin
        if (sts.loc_done) state_next = S_MARK;
        else              cmd.loc_step = 1'b1;
      end
      S_MARK: begin
        cmd.mark     = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = sts.at_top ? S_DONE : S_UP_RD;
      end
      S_UP_RD: state_next = S_UP_WR;
      S_UP_WR: begin
        cmd.up_wr  = 1'b1;
        state_next = sts.up_last ? S_DONE : S_UP_RD;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/bba_dpath.sv =====
module bba_dpath #(
  parameter int LEVELS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bba_pkg::SHIFT_W-1:0]  cfg_wdata,
  input  logic                         in_mode,
  input  logic [bba_pkg::REQ_W-1:0]    in_bytes,
  input  logic [bba_pkg::HANDLE_W-1:0] in_handle,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::sts_t                sts,
  output logic [1:0]                   out_status,
  output logic [bba_pkg::HANDLE_W-1:0] out_handle,
  output logic [bba_pkg::OFS_W-1:0]    out_offset,
  output logic [bba_pkg::LVL_W-1:0]    out_level
);

  localparam int NW    = LEVELS + 1;          // node index width
  localparam int NODES = (2 ** NW) - 1;
  localparam int LVW   = $clog2(LEVELS + 1);
  localparam int PW    = LEVELS;              // offset in smallest-block units
  localparam int RW    = bba_pkg::REQ_W;
  localparam int HW    = bba_pkg::HANDLE_W;
  localparam int OW    = bba_pkg::OFS_W;
  localparam int LW    = bba_pkg::LVL_W;

  // configuration and latched request
  logic [bba_pkg::SHIFT_W-1:0] shift;
  logic                        req_mode;
  logic [RW-1:0]               req_bytes;
  logic [HW-1:0]               req_handle;

  // tree walk
  logic [LVW-1:0] want;
  logic [NW-1:0]  node;
  logic [LVW-1:0] level;
  logic [PW-1:0]  unit_ofs;
  logic [NW-1:0]  clr_idx;

  // node store
  bba_pkg::node_st_t mem [NODES];
  bba_pkg::node_st_t rd_a;
  bba_pkg::node_st_t rd_b;

  // result holding and output registers
  bba_pkg::rsp_code_t res_code;
  logic [HW-1:0]      res_handle;
  logic [OW-1:0]      res_offset;
  logic [LW-1:0]      res_level;
  bba_pkg::rsp_code_t out_code;

  logic [LVW-1:0]    want_next;
  logic              nosp_next;
  logic [NW-1:0]     sub_size;
  logic [PW:0]       lvl_bit;
  logic [PW:0]       step_abs;
  logic [LVW-1:0]    step_lvl;
  logic              is_left;
  logic [NW-1:0]     sibling;
  logic [NW-1:0]     parent;
  logic [NW-1:0]     right_child;
  logic [NW-1:0]     target;
  bba_pkg::node_st_t left_st;
  bba_pkg::node_st_t right_st;
  bba_pkg::node_st_t merged;
  logic              found;
  logic              skip;
  logic              we;
  logic [NW-1:0]     waddr;
  bba_pkg::node_st_t wdata;
  logic [NW-1:0]     raddr_a;

  function automatic logic taken(input bba_pkg::node_st_t s);
    taken = (s inside {bba_pkg::ST_USED, bba_pkg::ST_FULL});
  endfunction

  // smallest level whose block covers the request
  always_comb begin
    want_next = '0;
    nosp_next = 1'b1;
    for (int l = LEVELS; l >= 0; l--) begin
      if ((int'(shift) + l >= RW) || (req_bytes <= (RW'(1) << (int'(shift) + l)))) begin
        want_next = LVW'(l);
        nosp_next = 1'b0;
      end
    end
  end

  assign sub_size = NW'({NW{1'b1}} >> (LEVELS - int'(level)));
  assign lvl_bit  = (PW + 1)'(1) << level;
  assign step_abs = (PW + 1)'(unit_ofs) + lvl_bit;
  assign target   = NW'(req_handle);

  // level of the next node in preorder after skipping a subtree
  always_comb begin
    step_lvl = '0;
    for (int b = PW - 1; b >= 0; b--) begin
      if (step_abs[b]) step_lvl = LVW'(b);
    end
  end

  assign found = (rd_a == bba_pkg::ST_UNUSED);
  assign skip  = !found && (taken(rd_a) || (level == want));

  assign right_child = node + (NW'(1) << level);

  assign is_left  = ((((PW + 1)'(unit_ofs)) & lvl_bit) == '0);
  assign sibling  = is_left ? node + sub_size : node - sub_size;
  assign parent   = is_left ? node - NW'(1) : sibling - NW'(1);
  assign left_st  = is_left ? rd_a : rd_b;
  assign right_st = is_left ? rd_b : rd_a;

  always_comb begin
    if (left_st == bba_pkg::ST_UNUSED && right_st == bba_pkg::ST_UNUSED) begin
      merged = bba_pkg::ST_UNUSED;
    end else if (taken(left_st) && taken(right_st)) begin
      merged = bba_pkg::ST_FULL;
    end else begin
      merged = bba_pkg::ST_SPLIT;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_idx == NW'(NODES - 1));
    sts.nosp       = nosp_next;
    sts.srch_found = found;
    sts.srch_end   = skip && step_abs[PW];
    sts.free_ok    = (int'(req_handle) < NODES) && (rd_a == bba_pkg::ST_USED);
    sts.loc_done   = (node == target) || (level == '0);
    sts.at_top     = (level == LVW'(LEVELS));
    sts.up_last    = (level == LVW'(LEVELS - 1));
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = bba_pkg::ST_UNUSED;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_idx;
    end else if (cmd.mark) begin
      we    = 1'b1;
      wdata = (req_mode == bba_pkg::MODE_ALLOC) ? bba_pkg::ST_USED : bba_pkg::ST_UNUSED;
    end else if (cmd.up_wr) begin
      we    = 1'b1;
      waddr = parent;
      wdata = merged;
    end
  end

  assign raddr_a = cmd.free_rd ? target : node;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[sibling];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift   <= bba_pkg::SHIFT_RESET;
      clr_idx <= '0;
    end else begin
      if (cfg_we) shift <= cfg_wdata;
      if (cmd.clr_step) clr_idx <= clr_idx + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode   <= in_mode;
      req_bytes  <= in_bytes;
      req_handle <= in_handle;
    end
    if (cmd.calc_want) want <= want_next;

    if (cmd.walk_init) begin
      node     <= '0;
      level    <= LVW'(LEVELS);
      unit_ofs <= '0;
    end else if (cmd.srch_step) begin
      if (found) begin
        // whole subtree is free: jump to its leftmost block at the wanted level
        node  <= node + NW'(level - want);
        level <= want;
      end else if (skip) begin
        node     <= node + sub_size;
        level    <= step_lvl;
        unit_ofs <= PW'(step_abs);
      end else begin
        node  <= node + NW'(1);
        level <= level - LVW'(1);
      end
    end else if (cmd.loc_step) begin
      if (target >= right_child) begin
        node     <= right_child;
        unit_ofs <= unit_ofs | PW'(lvl_bit >> 1);
      end else begin
        node <= node + NW'(1);
      end
      level <= level - LVW'(1);
    end else if (cmd.up_wr) begin
      node     <= parent;
      level    <= level + LVW'(1);
      unit_ofs <= PW'(((PW + 1)'(unit_ofs)) & ~lvl_bit);
    end

    if (cmd.res_load) begin
      res_code <= cmd.res_code;
      case (cmd.res_code)
        bba_pkg::RSP_OK: begin
          res_handle <= HW'(node);
          res_offset <= OW'(unit_ofs) << shift;
          res_level  <= LW'(level);
        end
        bba_pkg::RSP_BADFREE: begin
          res_handle <= req_handle;
          res_offset <= '0;
          res_level  <= '0;
        end
        default: begin
          res_handle <= '0;
          res_offset <= '0;
          res_level  <= '0;
        end
      endcase
    end

    if (cmd.out_load) begin
      out_code   <= res_code;
      out_handle <= res_handle;
      out_offset <= res_offset;
      out_level  <= res_level;
    end
  end

  assign out_status = out_code;

endmodule

// ===== hdl/bba_checker.sv =====
`include "assert_macros.svh"

module bba_checker #(
  parameter int LEVELS = 5
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [1:0]                   rsp_status,
  input logic [bba_pkg::HANDLE_W-1:0] rsp_handle,
  input logic [bba_pkg::OFS_W-1:0]    rsp_offset,
  input logic [bba_pkg::LVL_W-1:0]    rsp_level
);

  `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

  `BBA_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_handle) && $stable(rsp_offset) && $stable(rsp_level), "rsp payload changed while stalled")

  `BBA_ASSERT_NEXT(a_one_request, clk, rst, req_valid && req_ready, !req_ready, "second request taken while busy")

  `BBA_ASSERT_IMP(a_ok_level, clk, rst, rsp_valid && rsp_status == bba_pkg::RSP_OK, int'(rsp_level) <= LEVELS, "block level above tree root")

  `BBA_ASSERT_IMP(a_nospace_zero, clk, rst, rsp_valid && rsp_status == bba_pkg::RSP_NOSPACE, rsp_handle == '0 && rsp_offset == '0 && rsp_level == '0, "no-space result carries block fields")

endmodule

bind buddy_block_allocator bba_checker #(
  .LEVELS (LEVELS)
) u_bba_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_handle (rsp.block_handle),
  .rsp_offset (rsp.block_offset),
  .rsp_level  (rsp.block_level)
);

// ===== verif/tb_buddy_block_allocator.sv =====
module tb_buddy_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_LEVELS = 5;
  localparam int NODE_CNT    = (2 << TREE_LEVELS) - 1;
  localparam int ITEMS_PER_SHIFT = 270;

  typedef struct {
    logic                         mode;
    logic [bba_pkg::REQ_W-1:0]    bytes;
    logic [bba_pkg::HANDLE_W-1:0] handle;
  } blk_req_t;

  typedef struct {
    bba_pkg::rsp_code_t           status;
    logic [bba_pkg::HANDLE_W-1:0] handle;
    logic [bba_pkg::OFS_W-1:0]    ofs;
    logic [bba_pkg::LVL_W-1:0]    lvl;
  } blk_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bba_pkg::SHIFT_W-1:0] cfg_wdata;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  buddy_block_allocator #(.LEVELS(TREE_LEVELS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // allocator image: node states in preorder and the current block shift
  bba_pkg::node_st_t           tree_st [NODE_CNT] = '{default: bba_pkg::ST_UNUSED};
  logic [bba_pkg::SHIFT_W-1:0] shift_now = bba_pkg::SHIFT_RESET;

  blk_req_t    pending_q [$];
  blk_result_t expected_q [$];

  int fail_cnt    = 0;
  int n_alloc_ok  = 0;
  int n_nospace   = 0;
  int n_free_ok   = 0;
  int n_badfree   = 0;
  int n_settings  = 0;
  int calm_cnt [2] = '{0, 0};
  int gap_left    = 0;
  int stall_left  = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] blk_bytes(int lvl);
    return 64'd1 << (int'(shift_now) + lvl);
  endfunction

  function automatic bit is_taken(bba_pkg::node_st_t s);
    return (s inside {bba_pkg::ST_USED, bba_pkg::ST_FULL});
  endfunction

  // lowest-addressed unused node at level want that no used or full ancestor covers
  function automatic int find_free(int want);
    int cur;
    int lvl;
    bit blocked;
    for (int k = 0; k < (1 << (TREE_LEVELS - want)); k++) begin
      cur = 0;
      lvl = TREE_LEVELS;
      blocked = 1'b0;
      while (lvl > want) begin
        if (is_taken(tree_st[cur])) blocked = 1'b1;
        if (k[lvl-want-1]) cur += 1 << lvl;
        else cur += 1;
        lvl--;
      end
      if (!blocked && tree_st[cur] == bba_pkg::ST_UNUSED) return cur;
    end
    return -1;
  endfunction

  // walk down to node h, then rebuild every ancestor from its two children
  function automatic void settle(int h, output int lvl, output logic [63:0] ofs);
    int trail [TREE_LEVELS+1];
    int cur;
    int depth;
    int l;
    bba_pkg::node_st_t a;
    bba_pkg::node_st_t b;
    cur = 0;
    lvl = TREE_LEVELS;
    depth = 0;
    ofs = '0;
    while (cur != h && lvl > 0) begin
      trail[depth] = cur;
      depth++;
      if (h >= cur + (1 << lvl)) begin
        ofs += blk_bytes(lvl - 1);
        cur += 1 << lvl;
      end else begin
        cur += 1;
      end
      lvl--;
    end
    l = lvl;
    for (int i = depth - 1; i >= 0; i--) begin
      l++;
      a = tree_st[trail[i] + 1];
      b = tree_st[trail[i] + (1 << l)];
      if (a == bba_pkg::ST_UNUSED && b == bba_pkg::ST_UNUSED)
        tree_st[trail[i]] = bba_pkg::ST_UNUSED;
      else if (is_taken(a) && is_taken(b))
        tree_st[trail[i]] = bba_pkg::ST_FULL;
      else tree_st[trail[i]] = bba_pkg::ST_SPLIT;
    end
  endfunction

  function automatic blk_result_t serve(logic mode, logic [bba_pkg::REQ_W-1:0] bytes,
                                        logic [bba_pkg::HANDLE_W-1:0] fh);
    blk_result_t r;
    int want;
    int h;
    int lvl;
    logic [63:0] ofs;
    r.status = bba_pkg::RSP_OK;
    r.handle = '0;
    r.ofs    = '0;
    r.lvl    = '0;
    if (mode == bba_pkg::MODE_ALLOC) begin
      want = 0;
      while (want <= TREE_LEVELS && 64'(bytes) > blk_bytes(want)) want++;
      if (want > TREE_LEVELS) begin
        r.status = bba_pkg::RSP_NOSPACE;
        return r;
      end
      h = find_free(want);
      if (h < 0) begin
        r.status = bba_pkg::RSP_NOSPACE;
        return r;
      end
      tree_st[h] = bba_pkg::ST_USED;
    end else begin
      h = int'(fh);
      if (h >= NODE_CNT || tree_st[h] != bba_pkg::ST_USED) begin
        r.status = bba_pkg::RSP_BADFREE;
        r.handle = fh;
        return r;
      end
      tree_st[h] = bba_pkg::ST_UNUSED;
    end
    settle(h, lvl, ofs);
    r.handle = h[bba_pkg::HANDLE_W-1:0];
    r.ofs    = ofs[bba_pkg::OFS_W-1:0];
    r.lvl    = lvl[bba_pkg::LVL_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string field, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, field, got, want);
    fail_cnt++;
  endtask

  // wait count per item; now and then a calm stretch with no waits at all
  function automatic int draw_wait(int side);
    if (calm_cnt[side] > 0) begin
      calm_cnt[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_cnt[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // request driver: present the next pending item once the slot frees up
  always @(posedge clk) begin : drive_req
    blk_req_t it;
    if (rst) begin
      req_if.valid         <= 1'b0;
      req_if.mode          <= bba_pkg::MODE_ALLOC;
      req_if.request_bytes <= '0;
      req_if.free_handle   <= '0;
      gap_left <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left != 0) begin
        req_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        req_if.valid         <= 1'b1;
        req_if.mode          <= it.mode;
        req_if.request_bytes <= it.bytes;
        req_if.free_handle   <= it.handle;
        gap_left <= draw_wait(0);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result side backpressure: stall a drawn number of cycles after each transfer
  always @(posedge clk) begin : drive_rsp_ready
    int k;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      k = draw_wait(1);
      stall_left <= k;
      rsp_if.ready <= (k == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= (stall_left == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    blk_result_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        want = serve(req_if.mode, req_if.request_bytes, req_if.free_handle);
        expected_q.push_back(want);
        case (want.status)
          bba_pkg::RSP_OK: begin
            if (req_if.mode == bba_pkg::MODE_ALLOC) n_alloc_ok++;
            else n_free_ok++;
          end
          bba_pkg::RSP_NOSPACE: n_nospace++;
          default:              n_badfree++;
        endcase
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result, handle", rsp_if.block_handle, -1);
        end else begin
          want = expected_q.pop_front();
          if (rsp_if.status !== want.status)
            note_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.block_handle !== want.handle)
            note_mismatch("block_handle", rsp_if.block_handle, want.handle);
          if (rsp_if.block_offset !== want.ofs)
            note_mismatch("block_offset", rsp_if.block_offset, want.ofs);
          if (rsp_if.block_level !== want.lvl)
            note_mismatch("block_level", rsp_if.block_level, want.lvl);
        end
      end
    end
  end

  function automatic void queue_req(logic mode, logic [bba_pkg::REQ_W-1:0] bytes,
                                    logic [bba_pkg::HANDLE_W-1:0] handle);
    blk_req_t it;
    it.mode   = mode;
    it.bytes  = bytes;
    it.handle = handle;
    pending_q.push_back(it);
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0);
  endtask

  task automatic write_shift(logic [bba_pkg::SHIFT_W-1:0] v);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_now = v;
    n_settings++;
    @(negedge clk);
  endtask

  // allocations sized against the current shift, frees of live blocks and frees of random handles
  task automatic random_batch(int cnt);
    int live [$];
    int roll;
    int idx;
    int lvl;
    int free_cut;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] cap;
    logic [bba_pkg::REQ_W-1:0] bytes;
    cap = (64'd1 << bba_pkg::REQ_W) - 1;
    for (int n = 0; n < NODE_CNT; n++)
      if (tree_st[n] == bba_pkg::ST_USED) live.push_back(n);
    for (int i = 0; i < cnt; i++) begin
      roll = $urandom_range(0, 99);
      free_cut = (live.size() > 8) ? 55 : 30;
      if (roll < 8) begin
        queue_req(bba_pkg::MODE_FREE, bba_pkg::REQ_W'($urandom),
                  bba_pkg::HANDLE_W'($urandom_range(0, 63)));
      end else if (roll < free_cut && live.size() != 0) begin
        idx = $urandom_range(0, live.size() - 1);
        queue_req(bba_pkg::MODE_FREE, bba_pkg::REQ_W'($urandom),
                  bba_pkg::HANDLE_W'(live[idx]));
        live.delete(idx);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
          bytes = bba_pkg::REQ_W'($urandom);
        end else if (roll == 2 && blk_bytes(TREE_LEVELS) < cap) begin
          lo = blk_bytes(TREE_LEVELS) + 1;
          bytes = bba_pkg::REQ_W'($urandom_range(cap[31:0], lo[31:0]));
        end else begin
          lvl = $urandom_range(0, TREE_LEVELS);
          hi = (blk_bytes(lvl) < cap) ? blk_bytes(lvl) : cap;
          lo = (lvl == 0) ? 64'd0 : blk_bytes(lvl - 1) + 1;
          if (lo > hi) lo = hi;
          case ($urandom_range(0, 2))
            0:       bytes = bba_pkg::REQ_W'(lo);
            1:       bytes = bba_pkg::REQ_W'(hi);
            default: bytes = bba_pkg::REQ_W'($urandom_range(hi[31:0], lo[31:0]));
          endcase
        end
        queue_req(bba_pkg::MODE_ALLOC, bytes, bba_pkg::HANDLE_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [bba_pkg::SHIFT_W-1:0] shift_plan [7];
    int sent;
    int b;
    shift_plan = '{5'd0, 5'd20, 5'd31, 5'd3, 5'd10, 5'd16, 5'd1};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pass at the reset shift (1 KiB leaves, 32 KiB root)
    queue_req(bba_pkg::MODE_ALLOC, 26'd0, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd1024, 6'd63);
    queue_req(bba_pkg::MODE_ALLOC, 26'd1025, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd32768, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd32769, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'h3FFFFFF, 6'd0);
    queue_req(bba_pkg::MODE_FREE, 26'h3FFFFFF, 6'd6);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd6);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd63);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd0);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd5);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd7);
    queue_req(bba_pkg::MODE_ALLOC, 26'd32768, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd0, 6'd0);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd16384, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd9000, 6'd0);
    queue_req(bba_pkg::MODE_ALLOC, 26'd1, 6'd0);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd32);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd1);
    queue_req(bba_pkg::MODE_FREE, 26'd0, 6'd62);
    drain();

    foreach (shift_plan[p]) begin
      write_shift(shift_plan[p]);
      sent = 0;
      while (sent < ITEMS_PER_SHIFT) begin
        b = $urandom_range(1, 16);
        random_batch(b);
        drain();
        sent += b;
      end
    end

    // let any stray result show up before closing
    repeat (300) @(posedge clk);
    if (expected_q.size() != 0)
      note_mismatch("results outstanding", expected_q.size(), 0);
    $display("%0d requests checked over %0d shift settings plus the reset value",
             n_alloc_ok + n_nospace + n_free_ok + n_badfree, n_settings);
    $display("%0d blocks granted, %0d out of space, %0d released, %0d bad handles",
             n_alloc_ok, n_nospace, n_free_ok, n_badfree);
    if (fail_cnt == 0) begin
      $display("buddy_block_allocator regression: pass");
    end else begin
      $display("buddy_block_allocator regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("%0t ns: run did not complete in time", $time);
    $display("buddy_block_allocator regression: fail");
    $finish;
  end

endmodule
